// ===== hw/rtl/dtab_pkg.sv =====
package dtab_pkg;

  // Command codes carried in the input tuser.
  localparam logic [1:0] CMD_BLEND = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_DEPTH_LEVEL = 3'd0;
  localparam logic [2:0] REG_SCISSOR_X   = 3'd1;
  localparam logic [2:0] REG_SCISSOR_Y   = 3'd2;
  localparam logic [2:0] REG_SCISSOR_W   = 3'd3;
  localparam logic [2:0] REG_SCISSOR_H   = 3'd4;

  localparam int PIXEL_BITS = 40;

  // One stored pixel, depth in the top byte and blue in the bottom byte.
  typedef struct packed {
    logic [7:0] depth;
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load_item;
    logic calc;
    logic mem_rd;
    logic mult;
    logic mem_wr;
    logic clr_init;
    logic clr_wr;
    logic res_load;
  } ctl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic [1:0] cmd;
    logic       clr_done;
  } stat_t;

endpackage

// ===== hw/rtl/dtab_ram.sv =====
module dtab_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 76800
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/dtab_ctrl.sv =====
module dtab_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  dtab_pkg::stat_t  stat,
  output dtab_pkg::ctl_t   ctl
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDR = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.load_item = 1'b1;
          state_nxt     = S_ADDR;
        end
      end
      S_ADDR: begin
        ctl.calc = 1'b1;
        if (stat.cmd == dtab_pkg::CMD_CLEAR) begin
          ctl.clr_init = 1'b1;
          state_nxt    = S_CLR;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        ctl.mem_rd = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        ctl.mult  = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        ctl.mem_wr = 1'b1;
        state_nxt  = S_DONE;
      end
      S_CLR: begin
        ctl.clr_wr = 1'b1;
        if (stat.clr_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          ctl.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/dtab_dp.sv =====
module dtab_dp #(
  parameter int FB_WIDTH  = 320,
  parameter int FB_HEIGHT = 240
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dtab_pkg::ctl_t   ctl,
  output dtab_pkg::stat_t  stat,
  input  logic [55:0]      in_tdata,
  input  logic [1:0]       in_tuser,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [11:0]      cfg_wdata,
  output logic [39:0]      out_tdata,
  output logic [0:0]       out_tuser
);

  localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [10:0]   FBW_L = 11'(FB_WIDTH);
  localparam logic [10:0]   FBH_L = 11'(FB_HEIGHT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // Registers.
  logic [7:0]         depth_level_r;
  logic signed [10:0] scissor_x_r, scissor_y_r;
  logic [11:0]        scissor_w_r, scissor_h_r;

  logic [1:0]  cmd_r;
  logic [9:0]  x_r, y_r;
  logic [7:0]  red_r, green_r, blue_r, alpha_r;

  logic          inside_r, scis_ok_r, depth_ok_r;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [15:0]   sum_red_r, sum_green_r, sum_blue_r;

  dtab_pkg::pixel_t rd_pix, wr_pix, clr_pix, blend_pix;
  logic [dtab_pkg::PIXEL_BITS-1:0] rdata;

  logic          inside_nxt, scis_ok_nxt, blend_pass;
  logic signed [12:0] xs, ys, sx, sy, sx_end, sy_end;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          rd_ok;

  function automatic logic [15:0] mix_sum(input logic [7:0] src, input logic [7:0] dst,
                                          input logic [7:0] a);
    logic [15:0] p_src, p_dst;
    p_src = {8'd0, src} * {8'd0, a};
    p_dst = {8'd0, dst} * {8'd0, 8'hFF - a};
    return p_src + p_dst;
  endfunction

  // Exact floor(s / 255) for any s below 65280.
  function automatic logic [7:0] div255(input logic [15:0] s);
    logic [16:0] t;
    t = {1'b0, s} + 17'd1 + {9'd0, s[15:8]};
    return t[15:8];
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_level_r <= 8'd1;
      scissor_x_r   <= '0;
      scissor_y_r   <= '0;
      scissor_w_r   <= 12'd321;
      scissor_h_r   <= 12'd241;
    end else if (cfg_we) begin
      case (cfg_addr)
        dtab_pkg::REG_DEPTH_LEVEL: depth_level_r <= cfg_wdata[7:0];
        dtab_pkg::REG_SCISSOR_X:   scissor_x_r   <= cfg_wdata[10:0];
        dtab_pkg::REG_SCISSOR_Y:   scissor_y_r   <= cfg_wdata[10:0];
        dtab_pkg::REG_SCISSOR_W:   scissor_w_r   <= cfg_wdata;
        dtab_pkg::REG_SCISSOR_H:   scissor_h_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_r   <= in_tuser;
      x_r     <= in_tdata[9:0];
      y_r     <= in_tdata[19:10];
      red_r   <= in_tdata[27:20];
      green_r <= in_tdata[35:28];
      blue_r  <= in_tdata[43:36];
      alpha_r <= in_tdata[51:44];
    end
  end

  // Address and window test.
  always_comb begin
    xs          = $signed({3'b000, x_r});
    ys          = $signed({3'b000, y_r});
    sx          = {{2{scissor_x_r[10]}}, scissor_x_r};
    sy          = {{2{scissor_y_r[10]}}, scissor_y_r};
    sx_end      = sx + $signed({1'b0, scissor_w_r});
    sy_end      = sy + $signed({1'b0, scissor_h_r});
    inside_nxt  = ({1'b0, x_r} < FBW_L) && ({1'b0, y_r} < FBH_L);
    scis_ok_nxt = (xs >= sx) && (xs < sx_end) && (ys >= sy) && (ys < sy_end);
    addr_nxt    = inside_nxt ? AW'(y_r * FB_WIDTH + x_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.calc) begin
      inside_r  <= inside_nxt;
      scis_ok_r <= scis_ok_nxt;
      addr_r    <= addr_nxt;
    end
  end

  // Blend arithmetic on the fetched pixel.
  assign rd_pix = dtab_pkg::pixel_t'(rdata);

  always_ff @(posedge clk) begin
    if (ctl.mult) begin
      depth_ok_r  <= rd_pix.depth <= depth_level_r;
      sum_red_r   <= mix_sum(red_r, rd_pix.red, alpha_r);
      sum_green_r <= mix_sum(green_r, rd_pix.green, alpha_r);
      sum_blue_r  <= mix_sum(blue_r, rd_pix.blue, alpha_r);
    end
  end

  assign blend_pass = (cmd_r == dtab_pkg::CMD_BLEND) && inside_r && scis_ok_r && depth_ok_r;

  always_comb begin
    blend_pix.depth = depth_level_r;
    blend_pix.alpha = alpha_r;
    blend_pix.red   = div255(sum_red_r);
    blend_pix.green = div255(sum_green_r);
    blend_pix.blue  = div255(sum_blue_r);
    clr_pix.depth   = 8'h00;
    clr_pix.alpha   = 8'hFF;
    clr_pix.red     = red_r;
    clr_pix.green   = green_r;
    clr_pix.blue    = blue_r;
  end

  // Clear sweep counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (ctl.clr_init) begin
      clr_cnt_r <= '0;
    end else if (ctl.clr_wr) begin
      clr_cnt_r <= (clr_cnt_r == LAST_ADDR) ? '0 : clr_cnt_r + AW'(1);
    end
  end

  assign mem_we    = (ctl.mem_wr && blend_pass) || ctl.clr_wr;
  assign mem_waddr = ctl.clr_wr ? clr_cnt_r : addr_r;
  assign wr_pix    = ctl.clr_wr ? clr_pix : blend_pix;

  dtab_ram #(
    .WIDTH (dtab_pkg::PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wr_pix),
    .re    (ctl.mem_rd),
    .raddr (addr_r),
    .rdata (rdata)
  );

  // Result register; the fetched word stays put until the next read.
  assign rd_ok = (cmd_r == dtab_pkg::CMD_READ) && inside_r;

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      out_tuser[0] <= blend_pass;
      out_tdata    <= rd_ok ? {rd_pix.depth, rd_pix.alpha, rd_pix.blue, rd_pix.green,
                               rd_pix.red} : 40'd0;
    end
  end

  assign stat.cmd      = cmd_r;
  assign stat.clr_done = (clr_cnt_r == LAST_ADDR);

endmodule

// ===== hw/rtl/depth_tested_alpha_blend_rop_core.sv =====
// Raster-operation unit with a built-in FB_WIDTH x FB_HEIGHT frame store of
// blue, green, red, alpha and depth bytes. Each item carries a command: a blend
// fragment is scissored, bounds checked and depth tested against depth_level,
// then mixed into the stored pixel as floor((src*a + dst*(255-a))/255) per
// channel; a read returns the stored pixel (zero outside the buffer); a clear
// fills every pixel with the given color, alpha 255 and depth 0. Every item
// gives exactly one result. Blend, read and unused commands run through the
// read-modify-write sequence on the frame store (address, fetch, multiply,
// write, result) before the next item is accepted. A clear writes one pixel
// per cycle through the whole store by the sweep counter. The store holds no
// defined data after reset, so software must issue a clear before any blend
// or read. A finished result sits in an output register, and the next item
// is taken while it waits.
module depth_tested_alpha_blend_rop_core #(
  parameter int FB_WIDTH  = 320,
  parameter int FB_HEIGHT = 240
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // pixel_x, pixel_y, red, green, blue, alpha, zero pad
  input  logic [1:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_red, out_green, out_blue, out_alpha, out_depth
  output logic [0:0]  out_tuser,  // written
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [11:0] cfg_wdata
);

  dtab_pkg::ctl_t  ctl;
  dtab_pkg::stat_t stat;

  // The sequencer steps through one item at a time.
  dtab_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctl        (ctl)
  );

  // The datapath holds the item, the registers, the store and the result.
  dtab_dp #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // A stored fragment reports no pixel data.
  a_written_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == 40'd0))
    else $error("written result carries pixel data");

  // After an item is taken the block is not ready in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // A new result only appears when the sequencer has finished an item.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while idle");

endmodule
